// ===== src/sidec_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the power-of-ten table, character codes and controller/datapath interface types.
// No dependencies.
`default_nettype none

package sidec_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned IdxW   = 4;   // digit position 0..9
  localparam int unsigned DigW   = 4;   // digit value 0..9
  localparam int unsigned NumPos = 10;  // decimal positions in a 32-bit magnitude
  localparam int unsigned MultW  = 34;  // holds 9 * 10^9

  localparam logic [CharW-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'd45;

  localparam logic [MultW-1:0] POW10 [NumPos] = '{
    34'd1,
    34'd10,
    34'd100,
    34'd1000,
    34'd10000,
    34'd100000,
    34'd1000000,
    34'd10000000,
    34'd100000000,
    34'd1000000000
  };

  typedef struct packed {
    logic load;        // capture the input value and take its magnitude
    logic scan;        // find the most significant digit position
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the current digit, step to the next position
  } cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a character this cycle
    logic negative;    // captured value is negative
    logic idx_zero;    // current position is the units digit
  } status_t;

endpackage

`default_nettype wire

// ===== src/sidec_dpath.sv =====
// Datapath: magnitude register, digit extraction by compare against multiples of 10^k,
// and the character output register. Depends on sidec_pkg.
`default_nettype none

module sidec_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [sidec_pkg::ValueW-1:0]    value_i,
  input  wire sidec_pkg::cmd_t                 cmd_i,
  output sidec_pkg::status_t                   status_o,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output logic [sidec_pkg::CharW-1:0]          character_o,
  output logic                                 last_o
);

  logic [sidec_pkg::ValueW-1:0] mag_q, mag_d;
  logic                         neg_q;
  logic [sidec_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                         valid_q, valid_d;
  logic [sidec_pkg::CharW-1:0]  char_q, char_d;
  logic                         last_q, last_d;

  logic [sidec_pkg::IdxW-1:0]   msd_idx;
  logic [sidec_pkg::MultW-1:0]  pow;
  logic [sidec_pkg::MultW-1:0]  mult [10];
  logic [sidec_pkg::DigW-1:0]   digit;

  // Position of the leading digit: how many of 10^1..10^9 the magnitude reaches.
  always_comb begin
    msd_idx = '0;
    for (int k = 1; k < sidec_pkg::NumPos; k++) begin
      if ({2'b00, mag_q} >= sidec_pkg::POW10[k]) begin
        msd_idx = msd_idx + sidec_pkg::IdxW'(1);
      end
    end
  end

  // Digit is the largest m with m * 10^idx <= magnitude.
  always_comb begin
    pow   = sidec_pkg::POW10[idx_q];
    digit = '0;
    for (int m = 0; m < 10; m++) begin
      mult[m] = sidec_pkg::MultW'(pow * sidec_pkg::MultW'(m));
    end
    for (int m = 1; m < 10; m++) begin
      if ({2'b00, mag_q} >= mult[m]) begin
        digit = sidec_pkg::DigW'(m);
      end
    end
  end

  always_comb begin
    mag_d   = mag_q;
    idx_d   = idx_q;
    valid_d = valid_q & out_stall_i;
    char_d  = char_q;
    last_d  = last_q;
    if (cmd_i.load) begin
      mag_d = value_i[sidec_pkg::ValueW-1] ? (~value_i + sidec_pkg::ValueW'(1)) : value_i;
    end
    if (cmd_i.scan) begin
      idx_d = msd_idx;
    end
    if (cmd_i.emit_sign) begin
      valid_d = 1'b1;
      char_d  = sidec_pkg::CHAR_MINUS;
      last_d  = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      valid_d = 1'b1;
      char_d  = sidec_pkg::CHAR_ZERO + {4'b0000, digit};
      last_d  = (idx_q == '0);
      mag_d   = mag_q - mult[digit][sidec_pkg::ValueW-1:0];
      if (idx_q != '0) begin
        idx_d = idx_q - sidec_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
    if (cmd_i.load) begin
      neg_q <= value_i[sidec_pkg::ValueW-1];
    end
  end

  assign status_o.out_free = ~valid_q | ~out_stall_i;
  assign status_o.negative = neg_q;
  assign status_o.idx_zero = (idx_q == '0);

  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== src/sidec_ctrl.sv =====
// Controller: sequences load, leading-digit scan, sign and digit emission.
// Depends on sidec_pkg.
`default_nettype none

module sidec_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sidec_pkg::status_t  status_i,
  output sidec_pkg::cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!status_i.negative) begin
          state_d = ST_DIGIT;
        end else if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.idx_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// Digits are loaded in the digit state that follows the scan state; a negative value's '-'
// is loaded into the output register in the scan state. One character per cycle after that
// while the output is not stalled, each digit found by compare against multiples of 10^k.
// New values are taken only after the last digit. Reset clears the controller and output valid.
`default_nettype none

module signed_int_to_decimal_ascii_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sidec_pkg::ValueW-1:0]  value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sidec_pkg::CharW-1:0]        character_o,
  output logic                               last_o
);

  sidec_pkg::cmd_t    cmd;
  sidec_pkg::status_t status;

  sidec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sidec_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for signed_int_to_decimal_ascii_core: directed values, then random values,
// with each output character checked against a local decimal-text predictor.
// Depends on sidec_pkg and the core RTL.
`default_nettype none

module testbench;

  typedef struct packed {
    logic [sidec_pkg::CharW-1:0] code;
    logic                        last;
  } text_char_t;

  localparam int DirCount    = 21;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 24;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic [sidec_pkg::ValueW-1:0] value_i     = '0;
  logic                         out_stall_i = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [sidec_pkg::CharW-1:0]  character_o;
  logic                         last_o;

  text_char_t pending_chars[$];
  int         fail_count  = 0;
  int         idle_cycles = 0;
  bit         tx_idle_en  = 1'b0;
  bit         rx_idle_en  = 1'b0;
  bit         rx_hold_req = 1'b0;

  // Directed values; an empty text means the predictor supplies the characters.
  logic [sidec_pkg::ValueW-1:0] dir_value [DirCount] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'd999999999, 32'd1000000000, -32'sd1000000000, -32'sd999999999, 32'd123456789,
    32'h8000_0001, 32'd1999999999, -32'sd9, 32'd4096, 32'h5555_5555,
    32'hAAAA_AAAA
  };
  string dir_text [DirCount] = '{
    "0", "1", "-1", "2147483647", "-2147483648",
    "9", "10", "", "", "",
    "", "1000000000", "", "", "",
    "", "", "", "", "",
    ""
  };

  always #5 clk_i = ~clk_i;

  signed_int_to_decimal_ascii_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Appends the decimal text of a two's complement word to the expected characters.
  function automatic void predict_text(logic [sidec_pkg::ValueW-1:0] word);
    logic [sidec_pkg::ValueW-1:0] mag;
    logic [sidec_pkg::CharW-1:0]  code;
    logic [sidec_pkg::CharW-1:0]  digits[$];
    mag = word[sidec_pkg::ValueW-1] ? (~word + 1'b1) : word;
    do begin
      code = sidec_pkg::CHAR_ZERO + sidec_pkg::CharW'(mag % 10);
      digits.push_front(code);
      mag = mag / 10;
    end while (mag != 0);
    if (word[sidec_pkg::ValueW-1]) begin
      pending_chars.push_back('{code: sidec_pkg::CHAR_MINUS, last: 1'b0});
    end
    foreach (digits[i])
      pending_chars.push_back('{code: digits[i], last: (i == digits.size() - 1)});
  endfunction

  // Mostly uniform over digit counts so short and long texts both show up often.
  function automatic logic [sidec_pkg::ValueW-1:0] random_value();
    int unsigned                  ndig;
    longint                       base;
    longint                       hi;
    logic [sidec_pkg::ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom();
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'd0;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        ndig = $urandom_range(1, 10);
        base = 1;
        repeat (ndig - 1) base = base * 10;
        hi = base * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        v = $urandom_range(32'(hi), (ndig == 1) ? 32'd0 : 32'(base));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // Offers one value and holds it until the transaction completes.
  task automatic send_value(logic [sidec_pkg::ValueW-1:0] value, string text);
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (text.len() == 0) begin
      predict_text(value);
    end else begin
      for (int i = 0; i < text.len(); i++)
        pending_chars.push_back('{code: text[i], last: (i == text.len() - 1)});
    end
  endtask

  task automatic sender_gap();
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom();
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver_stall
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_chars
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character %0d (last %0d)", character_o, last_o);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.code) begin
          $error("character: expected %0d, got %0d", want.code, character_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no transaction happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) send_value(dir_value[i], dir_text[i]);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < 150; i++) begin
      sender_gap();
      send_value(random_value(), "");
    end

    // receiver holds off while values keep coming, so the input backs up
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 25; i++) send_value(random_value(), "");
    in_valid_i <= 1'b0;
    wait_drained();

    tx_idle_en = 1'b1;
    for (int i = 0; i < 135; i++) begin
      sender_gap();
      send_value(random_value(), "");
    end

    // full rate to the end
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 40; i++) send_value(random_value(), "");
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/sidec_pkg.sv
src/sidec_dpath.sv
src/sidec_ctrl.sv
src/signed_int_to_decimal_ascii_core.sv
dv/testbench.sv
